FILE: hw/rtl/pss_pkg.sv
`default_nettype none
package pss_pkg;

   localparam int MAX_PACKET_BYTES = 65536;
   localparam int COUNTER_WIDTH    = 32;
   localparam int SEQ_HEADER_BYTES = 8;
   localparam int QUEUE_DEPTH      = 4;

   localparam int LEN_W  = 16;
   localparam int SUM_W  = 48;
   localparam int SEQ_W  = 64;
   localparam int OUT_W  = 32;
   localparam int CNT_W  = COUNTER_WIDTH;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
   localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

   typedef logic [CNT_W-1:0] cnt_type;

   typedef enum logic [1:0] {
      OP_PACKET = 2'b01,
      OP_REPORT = 2'b10
   } op_type;

   typedef struct packed {
      logic              func;
      logic [LEN_W-1:0]  pkt_len;
      logic [SEQ_W-1:0]  seq;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0]  packet_count;
      logic [LEN_W-1:0]  min_len;
      logic [LEN_W-1:0]  max_len;
      logic [LEN_W-1:0]  avg_len;
      logic [SUM_W-1:0]  byte_sum;
      logic [OUT_W-1:0]  drop_count;
      logic [OUT_W-1:0]  out_of_order_count;
   } rsp_type;

   typedef struct packed {
      op_type            op;
      logic [LEN_W-1:0]  pkt_len;
      logic [SEQ_W-1:0]  seq;
   } item_type;

   typedef struct packed {
      logic      valid;
      item_type  item;
   } queue_head_type;

endpackage
`default_nettype wire

FILE: hw/rtl/pss_front.sv
`default_nettype none
module pss_front
   import pss_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire req_type  req,
   output logic          push,
   output item_type      push_item,
   input  wire logic     queue_full
);

   logic      slot_valid_ff, slot_valid_in;
   item_type  slot_ff, slot_in;
   logic      accept;
   logic      len_ok;

   assign push      = slot_valid_ff && !queue_full;
   assign push_item = slot_ff;
   assign req_stall = slot_valid_ff && queue_full;
   assign accept    = req_valid && !req_stall;

   assign len_ok = ({16'b0, req.pkt_len} >= 32'(SEQ_HEADER_BYTES)) &&
                   ({16'b0, req.pkt_len} <  32'(MAX_PACKET_BYTES));

   always_comb begin
      slot_valid_in = slot_valid_ff && !push;
      slot_in       = slot_ff;
      if (accept) begin
         // drop packets with a bad length here, they touch no state
         slot_valid_in   = req.func || len_ok;
         slot_in.op      = req.func ? OP_REPORT : OP_PACKET;
         slot_in.pkt_len = req.pkt_len;
         slot_in.seq     = req.seq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
      end
      slot_ff <= slot_in;
   end

endmodule
`default_nettype wire

FILE: hw/rtl/pss_queue.sv
`default_nettype none
module pss_queue
   import pss_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire item_type        push_item,
   output logic                 full,
   input  wire logic            pop,
   output queue_head_type       head
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   item_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]    fill_ff, fill_in;

   assign full       = (fill_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign head.valid = (fill_ff != '0);
   assign head.item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/pss_back.sv
`default_nettype none
module pss_back
   import pss_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire queue_head_type  head,
   output logic                 pop,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output rsp_type              rsp
);

   localparam int STEP_W = $clog2(LEN_W);

   cnt_type           count_ff, count_in;
   logic [LEN_W-1:0]  min_ff, min_in;
   logic [LEN_W-1:0]  max_ff, max_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SEQ_W-1:0]  head_seq_ff, head_seq_in;
   cnt_type           drop_ff, drop_in;
   cnt_type           ooo_ff, ooo_in;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   cnt_type           den_ff, den_in;
   cnt_type           rem_ff, rem_in;
   logic [LEN_W-1:0]  quo_ff, quo_in;

   logic              out_free;
   logic [SUM_W:0]    sum_ext;
   logic [SEQ_W-1:0]  gap_m1;
   logic [SEQ_W:0]    drop_ext;
   logic [CNT_W:0]    trial;
   logic              quo_bit;
   logic              avg_sat;

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pop       = head.valid &&
                      (head.item.op == OP_PACKET || (!busy_ff && out_free));

   assign sum_ext  = {1'b0, sum_ff} + (SUM_W+1)'(head.item.pkt_len);
   // seq - head - 1 without a separate decrement
   assign gap_m1   = head.item.seq + ~head_seq_ff;
   assign drop_ext = (SEQ_W+1)'(drop_ff) + {1'b0, gap_m1};
   assign avg_sat  = (64'(sum_ff[SUM_W-1:LEN_W]) >= 64'(count_ff));

   assign trial   = {rem_ff, quo_ff[LEN_W-1]};
   assign quo_bit = (trial >= {1'b0, den_ff});

   always_comb begin
      count_in     = count_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      sum_in       = sum_ff;
      head_seq_in  = head_seq_ff;
      drop_in      = drop_ff;
      ooo_in       = ooo_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      busy_in      = busy_ff;
      step_in      = step_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;

      // one restoring step per cycle, quotient shifts in from the bottom
      if (busy_ff) begin
         rem_in  = quo_bit ? CNT_W'(trial - {1'b0, den_ff}) : CNT_W'(trial);
         quo_in  = {quo_ff[LEN_W-2:0], quo_bit};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(LEN_W-1)) begin
            busy_in        = 1'b0;
            rsp_in.avg_len = {quo_ff[LEN_W-2:0], quo_bit};
            rsp_valid_in   = 1'b1;
         end
      end

      if (pop) begin
         case (head.item.op)
            OP_PACKET: begin
               count_in = (count_ff == CNT_MAX) ? count_ff : count_ff + 1'b1;
               if (head.item.pkt_len > max_ff) max_in = head.item.pkt_len;
               if (head.item.pkt_len < min_ff) min_in = head.item.pkt_len;
               sum_in = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
               if (head.item.seq == '0) begin
                  head_seq_in = '0;
               end else if (head.item.seq < head_seq_ff) begin
                  ooo_in = (ooo_ff == CNT_MAX) ? ooo_ff : ooo_ff + 1'b1;
                  if (drop_ff != '0) drop_in = drop_ff - 1'b1;
               end else begin
                  // gap of more than one: add the missing words
                  if (head.item.seq - head_seq_ff > 64'd1) begin
                     drop_in = (drop_ext > (SEQ_W+1)'(CNT_MAX)) ? CNT_MAX
                                                                 : CNT_W'(drop_ext);
                  end
                  head_seq_in = head.item.seq;
               end
            end
            OP_REPORT: begin
               rsp_in.packet_count       = OUT_W'(count_ff);
               rsp_in.byte_sum           = sum_ff;
               rsp_in.drop_count         = OUT_W'(drop_ff);
               rsp_in.out_of_order_count = OUT_W'(ooo_ff);
               if (count_ff == '0) begin
                  rsp_in.min_len = '0;
                  rsp_in.max_len = '0;
                  rsp_in.avg_len = '0;
                  rsp_valid_in   = 1'b1;
               end else begin
                  rsp_in.min_len = min_ff;
                  rsp_in.max_len = max_ff;
                  if (avg_sat) begin
                     rsp_in.avg_len = LEN_MAX;
                     rsp_valid_in   = 1'b1;
                  end else begin
                     busy_in = 1'b1;
                     step_in = '0;
                     den_in  = count_ff;
                     rem_in  = CNT_W'(sum_ff[SUM_W-1:LEN_W]);
                     quo_in  = sum_ff[LEN_W-1:0];
                  end
               end
               count_in = '0;
               min_in   = LEN_MAX;
               max_in   = '0;
               sum_in   = '0;
               drop_in  = '0;
               ooo_in   = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         min_ff       <= LEN_MAX;
         max_ff       <= '0;
         sum_ff       <= '0;
         head_seq_ff  <= '0;
         drop_ff      <= '0;
         ooo_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         busy_ff      <= 1'b0;
         step_ff      <= '0;
      end else begin
         count_ff     <= count_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         sum_ff       <= sum_in;
         head_seq_ff  <= head_seq_in;
         drop_ff      <= drop_in;
         ooo_ff       <= ooo_in;
         rsp_valid_ff <= rsp_valid_in;
         busy_ff      <= busy_in;
         step_ff      <= step_in;
      end
      rsp_ff <= rsp_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

endmodule
`default_nettype wire

FILE: hw/rtl/packet_stream_statistics_core.sv
// Packet words: one per cycle while req_stall is low, through a front slot and
// a 4-entry queue; a packet updates the interval counters when it leaves the queue.
// Report words: the result is registered directly when the interval is empty
// or the average saturates, else it comes from a 16-step divider.
// Packets keep flowing during the divide; a second report waits for it.
// Synchronous active-high reset clears counters, head sequence, front slot, queue and result valid.
`default_nettype none
module packet_stream_statistics_core
   import pss_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire req_type  req,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   output rsp_type       rsp
);

   logic            push;
   item_type        push_item;
   logic            queue_full;
   logic            pop;
   queue_head_type  head;

   pss_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req        (req),
      .push       (push),
      .push_item  (push_item),
      .queue_full (queue_full)
   );

   pss_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .head      (head)
   );

   pss_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

endmodule
`default_nettype wire

FILE: hw/rtl/pss_checker.sv
`default_nettype none
module pss_checker
   import pss_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_stall,
   input  wire logic     rsp_valid,
   input  wire logic     rsp_stall,
   input  wire rsp_type  rsp
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("result word changed while stalled");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.packet_count == '0 |->
         rsp.min_len == '0 && rsp.max_len == '0 && rsp.avg_len == '0)
      else $error("empty interval reports nonzero length");

   a_min_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.packet_count != '0 |-> rsp.min_len <= rsp.max_len)
      else $error("min length above max length");

   a_min_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.packet_count != '0 |->
         32'(rsp.min_len) >= 32'(SEQ_HEADER_BYTES))
      else $error("counted packet shorter than the header");

   a_idle_start: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("result word or input stall right after reset");

endmodule

bind packet_stream_statistics_core pss_checker u_pss_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);
`default_nettype wire

FILE: tb/stats_tb_pkg.sv
package stats_tb_pkg;

   // Function codes carried in the one-bit func field of a request word.
   localparam logic FUNC_PACKET = 1'b0;
   localparam logic FUNC_REPORT = 1'b1;

endpackage

FILE: tb/stats_checker.sv
module stats_checker
   import pss_pkg::*;
   import stats_tb_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_stall,
   input  wire req_type req,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_stall,
   input  wire rsp_type rsp,
   output int           fail_count,
   output int           pending,
   output int           words_taken,
   output int           reports_checked
);

   cnt_type          pkt_count;
   logic [LEN_W-1:0] len_min;
   logic [LEN_W-1:0] len_max;
   logic [SUM_W-1:0] byte_total;
   logic [SEQ_W-1:0] seq_head;
   cnt_type          lost;
   cnt_type          reordered;

   rsp_type reports_due[$];
   rsp_type due;
   int      fails = 0;
   int      taken = 0;
   int      checked = 0;

   task automatic start_interval();
      pkt_count  = '0;
      len_min    = LEN_MAX;
      len_max    = '0;
      byte_total = '0;
      lost       = '0;
      reordered  = '0;
   endtask

   task automatic account_packet(input logic [LEN_W-1:0] len, input logic [SEQ_W-1:0] s);
      logic [SEQ_W-1:0] gap;
      logic [SUM_W:0]   wide_sum;
      // drop malformed lengths without touching any counter
      if (len < SEQ_HEADER_BYTES || len >= MAX_PACKET_BYTES)
         return;
      if (pkt_count != CNT_MAX)
         pkt_count = pkt_count + 1'b1;
      if (len > len_max)
         len_max = len;
      if (len < len_min)
         len_min = len;
      wide_sum   = {1'b0, byte_total} + len;
      byte_total = (wide_sum > SUM_MAX) ? SUM_MAX : wide_sum[SUM_W-1:0];
      if (s == '0) begin
         seq_head = '0;
      end else if (s < seq_head) begin
         if (reordered != CNT_MAX)
            reordered = reordered + 1'b1;
         if (lost != '0)
            lost = lost - 1'b1;
      end else begin
         gap = s - seq_head;
         if (gap > 1) begin
            if (gap - 1 > SEQ_W'(CNT_MAX - lost))
               lost = CNT_MAX;
            else
               lost = lost + cnt_type'(gap - 1);
         end
         seq_head = s;
      end
   endtask

   function automatic rsp_type interval_summary();
      rsp_type          r;
      logic [SUM_W-1:0] quotient;
      r = '0;
      r.packet_count       = pkt_count;
      r.byte_sum           = byte_total;
      r.drop_count         = lost;
      r.out_of_order_count = reordered;
      if (pkt_count != '0) begin
         quotient  = byte_total / pkt_count;
         r.min_len = len_min;
         r.max_len = len_max;
         r.avg_len = (quotient > LEN_MAX) ? LEN_MAX : quotient[LEN_W-1:0];
      end
      return r;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start_interval();
         seq_head = '0;
         reports_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (reports_due.size() == 0) begin
               $display("%0t: unexpected report word, expected none actual %h", $time, rsp);
               fails++;
            end else begin
               due = reports_due.pop_front();
               check_field("packet_count", 64'(due.packet_count), 64'(rsp.packet_count));
               check_field("min_len", 64'(due.min_len), 64'(rsp.min_len));
               check_field("max_len", 64'(due.max_len), 64'(rsp.max_len));
               check_field("avg_len", 64'(due.avg_len), 64'(rsp.avg_len));
               check_field("byte_sum", 64'(due.byte_sum), 64'(rsp.byte_sum));
               check_field("drop_count", 64'(due.drop_count), 64'(rsp.drop_count));
               check_field("out_of_order_count", 64'(due.out_of_order_count),
                           64'(rsp.out_of_order_count));
               checked++;
            end
         end
         if (req_valid && !req_stall) begin
            taken++;
            if (req.func == FUNC_REPORT) begin
               reports_due.push_back(interval_summary());
               start_interval();
            end else begin
               account_packet(req.pkt_len, req.seq);
            end
         end
      end
      fail_count      <= fails;
      pending         <= reports_due.size();
      words_taken     <= taken;
      reports_checked <= checked;
   end

endmodule

FILE: tb/testbench.sv
module testbench;
   import pss_pkg::*;
   import stats_tb_pkg::*;

   localparam int IDLE_PCT     = 34;
   localparam int RANDOM_WORDS = 1300;
   localparam int HOLD_CYCLES  = 150;
   localparam int QUIET_LIMIT  = 3000;
   localparam int TAIL_CYCLES  = 40;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp;

   int   fail_count;
   int   pending;
   int   words_taken;
   int   reports_checked;
   int   gap_pct = IDLE_PCT;
   int   quiet_cycles = 0;
   logic calm = 1'b0;
   logic hold_go = 1'b0;

   packet_stream_statistics_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   stats_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req             (req),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp             (rsp),
      .fail_count      (fail_count),
      .pending         (pending),
      .words_taken     (words_taken),
      .reports_checked (reports_checked)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Offer one word and hold it until the core takes it.
   task automatic send_word(input logic f, input logic [LEN_W-1:0] len,
                            input logic [SEQ_W-1:0] s);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req       <= '{func: f, pkt_len: len, seq: s};
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Result side: random stalls, none while calm, one long hold on request.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go) begin
            hold_go   <= 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int               roll;
      int               report_pct;
      logic [SEQ_W-1:0] last_seq;
      logic [SEQ_W-1:0] s;
      logic [LEN_W-1:0] len;

      req_valid <= 1'b0;
      req       <= '0;
      reset     <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty interval, length extremes, bad lengths, gaps, reorder, restarts
      send_word(FUNC_REPORT, 16'h1234, 64'hDEAD_BEEF_0000_0001);
      send_word(FUNC_PACKET, 16'd8, 64'd1);
      send_word(FUNC_PACKET, 16'hFFFF, 64'd2);
      send_word(FUNC_PACKET, 16'd7, 64'd3);
      send_word(FUNC_PACKET, 16'd0, 64'd100);
      send_word(FUNC_PACKET, 16'd100, 64'd10);
      send_word(FUNC_PACKET, 16'd64, 64'd5);
      send_word(FUNC_PACKET, 16'd64, 64'd10);
      send_word(FUNC_PACKET, 16'd200, 64'd0);
      send_word(FUNC_PACKET, 16'd300, 64'd1);
      send_word(FUNC_REPORT, 16'd0, 64'd0);
      send_word(FUNC_REPORT, 16'hFFFF, '1);
      send_word(FUNC_PACKET, 16'd1000, 64'd3);
      send_word(FUNC_PACKET, 16'd1001, 64'd2);
      send_word(FUNC_PACKET, 16'd1003, 64'd1);
      send_word(FUNC_REPORT, 16'd0, 64'd0);
      send_word(FUNC_PACKET, 16'd512, '1);
      send_word(FUNC_PACKET, 16'd513, 64'hFFFF_FFFF_FFFF_FFFE);
      send_word(FUNC_PACKET, 16'd514, '1);
      send_word(FUNC_REPORT, 16'd0, 64'd0);
      send_word(FUNC_PACKET, 16'd9, 64'd0);
      send_word(FUNC_PACKET, 16'hAAAA, 64'h8000_0000_0000_0000);
      send_word(FUNC_PACKET, 16'h5555, 64'h5555_5555_5555_5555);
      send_word(FUNC_REPORT, 16'd0, 64'd0);
      drain();

      last_seq = '0;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == 400)
            calm <= 1'b1;
         if (n == 650)
            calm <= 1'b0;
         gap_pct = (n >= 400 && n < 650) ? 0 : IDLE_PCT;
         // hold the result side and keep pushing report-heavy traffic
         if (n == 200)
            hold_go <= 1'b1;
         report_pct = (n >= 200 && n < 260) ? 35 : 8;
         if (n == 800)
            drain();

         if ($urandom_range(99) < report_pct) begin
            send_word(FUNC_REPORT, 16'($urandom), {$urandom, $urandom});
         end else begin
            roll = $urandom_range(99);
            if (roll < 70)
               s = last_seq + 1;
            else if (roll < 78)
               s = last_seq + 2 + $urandom_range(30);
            else if (roll < 84)
               s = last_seq - $urandom_range(1, 6);
            else if (roll < 88)
               s = last_seq;
            else if (roll < 91)
               s = '0;
            else if (roll < 94)
               s = {$urandom, $urandom};
            else if (roll < 97)
               s = '1 - $urandom_range(3);
            else
               s = SEQ_W'($urandom_range(1, 50));
            if (s == '0)
               last_seq = '0;
            else if (s >= last_seq)
               last_seq = s;

            roll = $urandom_range(99);
            if (roll < 55)
               len = LEN_W'($urandom_range(8, 1500));
            else if (roll < 75)
               len = 16'($urandom);
            else if (roll < 83)
               len = LEN_W'($urandom_range(0, 7));
            else if (roll < 91)
               len = LEN_MAX;
            else if (roll < 96)
               len = LEN_W'(SEQ_HEADER_BYTES);
            else
               len = LEN_W'($urandom_range(9, 64));
            send_word(FUNC_PACKET, len, s);
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run took %0d words and checked %0d interval reports,", words_taken,
               reports_checked);
      $display("with bad lengths, restarts, gaps, reordering, saturated drops and stalls.");
      if (fail_count == 0 && pending == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/pss_pkg.sv
hw/rtl/pss_front.sv
hw/rtl/pss_queue.sv
hw/rtl/pss_back.sv
hw/rtl/packet_stream_statistics_core.sv
hw/rtl/pss_checker.sv
tb/stats_tb_pkg.sv
tb/stats_checker.sv
tb/testbench.sv
